// File: sv/udf_pkg.sv
package udf_pkg;

    typedef enum logic [1:0] {
        SIZE_32  = 2'd0,
        SIZE_8   = 2'd1,
        SIZE_16  = 2'd2,
        SIZE_ALL = 2'd3
    } size_mode_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_NORM,
        CONV_HOLD
    } conv_state_t;

    typedef enum logic {
        EMIT_IDLE,
        EMIT_RUN
    } emit_state_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic       has_width;
        logic [5:0] field_width;
        logic       has_precision;
        logic [5:0] precision;
        logic       left_align;
        logic       zero_pad;
        logic       is_zero;
    } job_t;

endpackage

// File: sv/udf_conv.sv
module udf_conv #(
    parameter int VALUE_BITS = 64,
    parameter int DIGITS = 20,
    localparam int ND_W = $clog2(DIGITS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [63:0]           s_value,
    input  logic [1:0]            s_size_mode,
    input  logic                  s_has_width,
    input  logic [5:0]            s_field_width,
    input  logic                  s_has_precision,
    input  logic [5:0]            s_precision,
    input  logic                  s_left_align,
    input  logic                  s_zero_pad,
    output logic                  job_valid,
    input  logic                  job_ready,
    output udf_pkg::job_t         job_ctl,
    output logic [4*DIGITS-1:0]   job_bcd,
    output logic [ND_W-1:0]       job_ndig
);
    import udf_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int BCD_W = 4 * DIGITS;

    conv_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0]  bin_reg, bin_next;
    logic [VALUE_BITS-1:0]  vmask;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ND_W-1:0]        ndig_reg, ndig_next;
    job_t                   ctl_reg, ctl_next;
    logic                   top_zero;

    always_comb begin
        case (s_size_mode)
            SIZE_8:   vmask = VALUE_BITS'(s_value[7:0]);
            SIZE_16:  vmask = VALUE_BITS'(s_value[15:0]);
            SIZE_32:  vmask = VALUE_BITS'(s_value[31:0]);
            default:  vmask = s_value[VALUE_BITS-1:0];
        endcase
    end

    // double dabble: add three to every digit of five or more, then shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    assign top_zero = (bcd_reg[BCD_W-1 -: 4] == 4'd0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CONV_IDLE: begin
                if (s_valid) begin
                    state_next = CONV_SHIFT;
                end
            end
            CONV_SHIFT: begin
                if (cnt_reg == '0) begin
                    state_next = CONV_NORM;
                end
            end
            CONV_NORM: begin
                if (!top_zero || ndig_reg == ND_W'(1)) begin
                    state_next = CONV_HOLD;
                end
            end
            CONV_HOLD: begin
                if (job_ready) begin
                    state_next = CONV_IDLE;
                end
            end
            default: state_next = CONV_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == CONV_IDLE);
        job_valid = (state_reg == CONV_HOLD);
        job_ctl   = ctl_reg;
        job_bcd   = bcd_reg;
        job_ndig  = ndig_reg;
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        ndig_next = ndig_reg;
        ctl_next  = ctl_reg;
        case (state_reg)
            CONV_IDLE: begin
                if (s_valid) begin
                    bin_next               = vmask;
                    bcd_next               = '0;
                    cnt_next               = CNT_W'(VALUE_BITS - 1);
                    ndig_next              = ND_W'(DIGITS);
                    ctl_next.has_width     = s_has_width;
                    ctl_next.field_width   = s_field_width;
                    ctl_next.has_precision = s_has_precision;
                    ctl_next.precision     = s_precision;
                    ctl_next.left_align    = s_left_align;
                    ctl_next.zero_pad      = s_zero_pad;
                    ctl_next.is_zero       = (vmask == '0);
                end
            end
            CONV_SHIFT: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            CONV_NORM: begin
                // drop leading zero digits, keeping at least one
                if (top_zero && ndig_reg != ND_W'(1)) begin
                    bcd_next  = bcd_reg << 4;
                    ndig_next = ndig_reg - ND_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        ndig_reg <= ndig_next;
        ctl_reg  <= ctl_next;
    end

endmodule

// File: sv/udf_emit.sv
module udf_emit #(
    parameter int MAX_FIELD = 32,
    parameter int DIGITS = 20,
    localparam int ND_W = $clog2(DIGITS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  udf_pkg::job_t         job_ctl,
    input  logic [4*DIGITS-1:0]   job_bcd,
    input  logic [ND_W-1:0]       job_ndig,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_char,
    output logic [5:0]            m_field_length,
    output logic                  m_last_char
);
    import udf_pkg::*;

    localparam int LW    = $clog2(MAX_FIELD + 1);
    localparam int CW    = LW + 1;
    localparam int BCD_W = 4 * DIGITS;

    emit_state_t       state_reg, state_next;
    logic [LW-1:0]     k_reg, k_next;
    logic [LW-1:0]     total_reg, total_next;
    logic [LW-1:0]     b1_reg, b1_next;
    logic [LW-1:0]     b2_reg, b2_next;
    logic [LW-1:0]     b3_reg, b3_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        char_reg, char_next;
    logic [5:0]        len_reg, len_next;
    logic              last_reg, last_next;

    logic [CW-1:0]     w_sat, p_sat, nd, eff_p, shown, body, total, lead, zeros;
    logic              zp, eff_has_w, eff_has_p;
    logic              fire, k_last, in_digits;
    logic [7:0]        ch;

    // field layout from the format flags and the digit count
    always_comb begin
        w_sat = (CW'(job_ctl.field_width) > CW'(MAX_FIELD)) ?
                CW'(MAX_FIELD) : CW'(job_ctl.field_width);
        p_sat = (CW'(job_ctl.precision) > CW'(MAX_FIELD)) ?
                CW'(MAX_FIELD) : CW'(job_ctl.precision);
        nd    = CW'(job_ndig);
        zp    = job_ctl.has_width && !job_ctl.left_align && job_ctl.zero_pad &&
                !job_ctl.has_precision;
        eff_has_p = job_ctl.has_precision || zp;
        eff_has_w = job_ctl.has_width && !zp;
        eff_p = zp ? ((w_sat > nd) ? w_sat : nd) : p_sat;
        shown = (job_ctl.is_zero && eff_has_p && eff_p == '0) ? '0 : nd;
        body  = (eff_has_p && eff_p > shown) ? eff_p : shown;
        total = (eff_has_w && w_sat > body) ? w_sat : body;
        lead  = (eff_has_w && !job_ctl.left_align) ? total - body : '0;
        zeros = body - shown;
    end

    always_comb begin
        k_last    = ((k_reg + LW'(1)) == total_reg);
        in_digits = 1'b0;
        if (k_reg < b1_reg) begin
            ch = CHAR_SPACE;
        end else if (k_reg < b2_reg) begin
            ch = CHAR_ZERO;
        end else if (k_reg < b3_reg) begin
            ch        = CHAR_ZERO + {4'd0, dig_reg[BCD_W-1 -: 4]};
            in_digits = 1'b1;
        end else begin
            ch = CHAR_SPACE;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EMIT_IDLE: begin
                if (job_valid && total != '0) begin
                    state_next = EMIT_RUN;
                end
            end
            EMIT_RUN: begin
                if (fire && k_last) begin
                    state_next = EMIT_IDLE;
                end
            end
            default: state_next = EMIT_IDLE;
        endcase
    end

    always_comb begin
        job_ready      = (state_reg == EMIT_IDLE);
        fire           = (state_reg == EMIT_RUN) && (!m_valid_reg || m_ready);
        m_valid        = m_valid_reg;
        m_out_char     = char_reg;
        m_field_length = len_reg;
        m_last_char    = last_reg;
    end

    always_comb begin
        k_next       = k_reg;
        total_next   = total_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        b3_next      = b3_reg;
        dig_next     = dig_reg;
        char_next    = char_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (job_ready && job_valid) begin
            k_next     = '0;
            total_next = LW'(total);
            b1_next    = LW'(lead);
            b2_next    = LW'(lead + zeros);
            b3_next    = LW'(lead + zeros + shown);
            dig_next   = job_bcd;
        end
        if (fire) begin
            k_next       = k_reg + LW'(1);
            char_next    = ch;
            len_next     = 6'(total_reg);
            last_next    = k_last;
            m_valid_next = 1'b1;
            if (in_digits) begin
                dig_next = dig_reg << 4;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EMIT_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        total_reg <= total_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        b3_reg    <= b3_next;
        dig_reg   <= dig_next;
        char_reg  <= char_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
    end

endmodule

// File: sv/unsigned_decimal_formatter.sv
// Unsigned decimal field formatter (%u style).
// Input channel s_*: one beat carries a value, a size mode (32, 8, 16 or all
// VALUE_BITS bits) and the width, precision, left-align and zero-pad flags.
// Output channel m_*: one beat per character of the padded field, with the
// total field length on every beat and m_last_char on the final one. An
// empty field gives no beats.
// The converter shifts the value in one bit per cycle through a BCD register,
// then drops leading zero digits one per cycle, then hands the digits to the
// character sequencer. s_ready is high only while the converter is free.
// The sequencer emits one character per cycle unless m_ready holds it back,
// from an output register, and works on one field while the next value converts.
// When m_ready is low the current character holds and the converter stalls
// once its result is waiting. Reset empties both stages; nothing is pending.
module unsigned_decimal_formatter #(
    parameter int MAX_FIELD = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    input  logic [1:0]  s_size_mode,
    input  logic        s_has_width,
    input  logic [5:0]  s_field_width,
    input  logic        s_has_precision,
    input  logic [5:0]  s_precision,
    input  logic        s_left_align,
    input  logic        s_zero_pad,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic [5:0]  m_field_length,
    output logic        m_last_char
);
    import udf_pkg::*;

    localparam int DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
    localparam int ND_W   = $clog2(DIGITS + 1);

    logic                 job_valid;
    logic                 job_ready;
    job_t                 job_ctl;
    logic [4*DIGITS-1:0]  job_bcd;
    logic [ND_W-1:0]      job_ndig;

    udf_conv #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_conv (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_size_mode     (s_size_mode),
        .s_has_width     (s_has_width),
        .s_field_width   (s_field_width),
        .s_has_precision (s_has_precision),
        .s_precision     (s_precision),
        .s_left_align    (s_left_align),
        .s_zero_pad      (s_zero_pad),
        .job_valid       (job_valid),
        .job_ready       (job_ready),
        .job_ctl         (job_ctl),
        .job_bcd         (job_bcd),
        .job_ndig        (job_ndig)
    );

    udf_emit #(
        .MAX_FIELD (MAX_FIELD),
        .DIGITS    (DIGITS)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job_ctl        (job_ctl),
        .job_bcd        (job_bcd),
        .job_ndig       (job_ndig),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_field_length (m_field_length),
        .m_last_char    (m_last_char)
    );

`ifndef SYNTH
    // converter busy after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while converter busy");

    // handed-over digits hold while the sequencer is busy
    a_job_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && !job_ready |=> job_valid && $stable(job_bcd) && $stable(job_ndig))
        else $error("job dropped or changed before handover");

    // a field continues without gaps and keeps its length
    a_field_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_char |=>
            m_valid && m_field_length == $past(m_field_length))
        else $error("field broken or length changed mid-field");

    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_field_length != 6'd0 || MAX_FIELD >= 64)
        else $error("character emitted for an empty field");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
    import udf_pkg::*;

    localparam int MAX_FIELD = 32;
    localparam int VALUE_BITS = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_TAIL = 20;

    typedef struct {
        logic [63:0] value;
        size_mode_t  size_mode;
        logic        has_width;
        logic [5:0]  field_width;
        logic        has_precision;
        logic [5:0]  precision;
        logic        left_align;
        logic        zero_pad;
    } fmt_req_t;

    typedef struct {
        logic [7:0] ch;
        logic [5:0] field_len;
        logic       is_last;
    } field_char_t;

    class field_checker;
        field_char_t pending_chars[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100) begin
                $display("mismatch: %s", msg);
            end
            mismatches++;
        endtask

        // expands one request into the characters of its decimal field
        function void note_item(fmt_req_t r);
            logic [63:0] v;
            logic [63:0] t;
            logic [7:0]  digs [20];
            int ndig, w, p, shown, body, total, lead, zeros, k;
            bit has_w, has_p;
            field_char_t c;
            v = r.value;
            case (r.size_mode)
                SIZE_32: begin
                    v = v & 64'h0000_0000_FFFF_FFFF;
                end
                SIZE_8: begin
                    v = v & 64'h0000_0000_0000_00FF;
                end
                SIZE_16: begin
                    v = v & 64'h0000_0000_0000_FFFF;
                end
                default: begin
                end
            endcase
            has_w = r.has_width;
            has_p = r.has_precision;
            w = (r.field_width > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
            p = (r.precision > MAX_FIELD) ? MAX_FIELD : int'(r.precision);
            t = v;
            ndig = 0;
            do begin
                digs[ndig] = CHAR_ZERO + 8'(t % 64'd10);
                t = t / 64'd10;
                ndig++;
            end while (t != 0);
            // zero pad: width becomes the minimum digit count
            if (has_w && !r.left_align && r.zero_pad && !has_p) begin
                p = (w > ndig) ? w : ndig;
                has_p = 1'b1;
                has_w = 1'b0;
            end
            shown = (v == 0 && has_p && p == 0) ? 0 : ndig;
            body = (has_p && p > shown) ? p : shown;
            total = (has_w && w > body) ? w : body;
            if (total > MAX_FIELD) begin
                total = MAX_FIELD;
            end
            zeros = body - shown;
            lead = (has_w && !r.left_align) ? total - body : 0;
            for (k = 0; k < total; k++) begin
                if (k < lead) begin
                    c.ch = CHAR_SPACE;
                end else if (k < lead + zeros) begin
                    c.ch = CHAR_ZERO;
                end else if (k < lead + zeros + shown) begin
                    c.ch = digs[shown - 1 - (k - lead - zeros)];
                end else begin
                    c.ch = CHAR_SPACE;
                end
                c.field_len = 6'(total);
                c.is_last = (k == total - 1);
                pending_chars.push_back(c);
            end
        endfunction

        task check_char(logic [7:0] ch, logic [5:0] field_len, logic is_last);
            field_char_t e;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h", ch));
            end else begin
                e = pending_chars.pop_front();
                if (ch !== e.ch) begin
                    report_mismatch($sformatf("char %h, want %h", ch, e.ch));
                end
                if (field_len !== e.field_len) begin
                    report_mismatch($sformatf("length %0d, want %0d", field_len, e.field_len));
                end
                if (is_last !== e.is_last) begin
                    report_mismatch($sformatf("last %b, want %b", is_last, e.is_last));
                end
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_value = '0;
    logic [1:0]  s_size_mode = '0;
    logic        s_has_width = 1'b0;
    logic [5:0]  s_field_width = '0;
    logic        s_has_precision = 1'b0;
    logic [5:0]  s_precision = '0;
    logic        s_left_align = 1'b0;
    logic        s_zero_pad = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic [5:0]  m_field_length;
    logic        m_last_char;

    field_checker sb = new();
    bit quiet_tail = 1'b0;
    int idle_cycles = 0;

    unsigned_decimal_formatter #(
        .MAX_FIELD(MAX_FIELD),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .s_size_mode(s_size_mode),
        .s_has_width(s_has_width),
        .s_field_width(s_field_width),
        .s_has_precision(s_has_precision),
        .s_precision(s_precision),
        .s_left_align(s_left_align),
        .s_zero_pad(s_zero_pad),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_char(m_out_char),
        .m_field_length(m_field_length),
        .m_last_char(m_last_char)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic fmt_req_t mk(logic [63:0] value, size_mode_t mode, logic hw,
                                    logic [5:0] w, logic hp, logic [5:0] p,
                                    logic la, logic zp);
        fmt_req_t r;
        r.value = value;
        r.size_mode = mode;
        r.has_width = hw;
        r.field_width = w;
        r.has_precision = hp;
        r.precision = p;
        r.left_align = la;
        r.zero_pad = zp;
        return r;
    endfunction

    function automatic logic [5:0] random_count();
        if ($urandom_range(0, 7) == 0) begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(0, 24));
    endfunction

    function automatic fmt_req_t random_item();
        fmt_req_t r;
        logic [63:0] p10;
        p10 = 64'd1;
        case ($urandom_range(0, 7))
            0: r.value = '0;
            1: r.value = 64'($urandom_range(0, 99));
            2: begin
                repeat ($urandom_range(0, 19)) p10 = p10 * 64'd10;
                r.value = p10 - 64'd1 + 64'($urandom_range(0, 2));
            end
            3: r.value = {$urandom, $urandom};
            4: r.value = '1;
            default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        r.size_mode = size_mode_t'($urandom_range(0, 3));
        r.has_width = 1'($urandom_range(0, 1));
        r.field_width = random_count();
        r.has_precision = 1'($urandom_range(0, 1));
        r.precision = random_count();
        r.left_align = 1'($urandom_range(0, 1));
        r.zero_pad = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_item(input fmt_req_t r);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= r.value;
        s_size_mode <= r.size_mode;
        s_has_width <= r.has_width;
        s_field_width <= r.field_width;
        s_has_precision <= r.has_precision;
        s_precision <= r.precision;
        s_left_align <= r.left_align;
        s_zero_pad <= r.zero_pad;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(r);
    endtask

    task automatic run_directed();
        send_item(mk('0, SIZE_32, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk('0, SIZE_32, 1'b0, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0));
        send_item(mk('0, SIZE_32, 1'b1, 6'd5, 1'b1, 6'd0, 1'b0, 1'b0));
        send_item(mk('0, SIZE_32, 1'b1, 6'd5, 1'b1, 6'd0, 1'b1, 1'b0));
        send_item(mk(64'd7, SIZE_32, 1'b0, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0));
        send_item(mk('1, SIZE_ALL, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk('1, SIZE_32, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk('1, SIZE_8, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk('1, SIZE_16, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk(64'd42, SIZE_32, 1'b1, 6'd10, 1'b0, 6'd0, 1'b0, 1'b1));
        send_item(mk(64'd42, SIZE_32, 1'b1, 6'd10, 1'b1, 6'd4, 1'b0, 1'b1));
        send_item(mk(64'd42, SIZE_32, 1'b1, 6'd10, 1'b0, 6'd0, 1'b1, 1'b1));
        send_item(mk(64'd42, SIZE_32, 1'b0, 6'd10, 1'b0, 6'd0, 1'b0, 1'b1));
        send_item(mk(64'd9, SIZE_ALL, 1'b1, 6'd63, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk(64'd9, SIZE_ALL, 1'b0, 6'd0, 1'b1, 6'd63, 1'b0, 1'b0));
        send_item(mk('1, SIZE_ALL, 1'b1, 6'd8, 1'b1, 6'd40, 1'b0, 1'b0));
        send_item(mk(64'd123, SIZE_8, 1'b1, 6'd20, 1'b0, 6'd0, 1'b1, 1'b0));
        send_item(mk('1, SIZE_ALL, 1'b1, 6'd63, 1'b0, 6'd0, 1'b0, 1'b1));
        send_item(mk(64'd55, SIZE_16, 1'b0, 6'd63, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk(64'd55, SIZE_16, 1'b0, 6'd0, 1'b0, 6'd63, 1'b0, 1'b0));
        send_item(mk(64'd123456, SIZE_ALL, 1'b1, 6'd3, 1'b0, 6'd0, 1'b0, 1'b0));
        send_item(mk('0, SIZE_32, 1'b1, 6'd0, 1'b0, 6'd0, 1'b0, 1'b1));
        send_item(mk('0, SIZE_32, 1'b1, 6'd8, 1'b0, 6'd0, 1'b0, 1'b1));
        send_item(mk(64'h8000_0000_0000_0000, SIZE_ALL, 1'b1, 6'd25, 1'b1, 6'd22,
                     1'b1, 1'b1));
    endtask

    task automatic run_random();
        int i;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                // hold off until the output side has drained
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL) begin
                quiet_tail = 1'b1;
            end
            send_item(random_item());
        end
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if (quiet_tail || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_out_char, m_field_length, m_last_char);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/udf_pkg.sv
sv/udf_conv.sv
sv/udf_emit.sv
sv/unsigned_decimal_formatter.sv
verif/tb_top.sv
